[src/assert_macros.svh]
// Assertion helpers shared by the ranging core files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UER_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define UER_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define UER_ASSERT(lbl, clk, rstn, prop)
`define UER_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/uer_pkg.sv]
`default_nettype none

package uer_pkg;

	localparam int PULSE_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF = 20;

	// Register field widths and indexes.
	localparam int PERIOD_W  = 20;
	localparam int WIDTH_W   = 10;
	localparam int TIMEOUT_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_PING_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd2;

	localparam logic [PERIOD_W-1:0]  PING_PERIOD_RST   = 20'd100000;
	localparam logic [WIDTH_W-1:0]   TRIGGER_WIDTH_RST = 10'd10;
	localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST  = 20'd30000;

	// Phase codes.
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_TRIG    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RISE    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_FALL    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RECOVER = 3'd4;

	// distance_mm = (pulse * PULSE_SCALE + ROUND_OFS) / DIV_MOD
	localparam int DIST_W      = 14;
	localparam int REM_W       = 6;
	localparam int PULSE_SCALE = 10;
	localparam int ROUND_OFS   = 29;
	localparam int DIV_MOD     = 58;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic start;
		logic inc;
	} dist_ctrl_t;

endpackage

`default_nettype wire

[src/uer_dist_track.sv]
`default_nettype none
`include "assert_macros.svh"

// Keeps quotient and remainder of (pulse*10+29)/58 as the pulse count steps
// up by one, so no divider is needed.
module uer_dist_track (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire uer_pkg::dist_ctrl_t          ctrl,
	output logic [uer_pkg::DIST_W-1:0]        track_mm
);

	localparam int SUM_W = uer_pkg::REM_W + 1;

	logic [uer_pkg::REM_W-1:0]  rem_q;
	logic [uer_pkg::DIST_W-1:0] dist_q;
	logic [SUM_W-1:0]           rem_sum;

	assign rem_sum = SUM_W'(rem_q) + SUM_W'(uer_pkg::PULSE_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dist_q <= '0;
		end else if (ctrl.start) begin
			// A pulse of one tick.
			rem_q  <= uer_pkg::REM_W'(uer_pkg::PULSE_SCALE + uer_pkg::ROUND_OFS);
			dist_q <= '0;
		end else if (ctrl.inc && (dist_q != uer_pkg::DIST_MAX)) begin
			if (rem_sum >= SUM_W'(uer_pkg::DIV_MOD)) begin
				rem_q  <= uer_pkg::REM_W'(rem_sum - SUM_W'(uer_pkg::DIV_MOD));
				dist_q <= dist_q + uer_pkg::DIST_W'(1);
			end else begin
				rem_q <= uer_pkg::REM_W'(rem_sum);
			end
		end
	end

	assign track_mm = dist_q;

	`UER_ASSERT(a_rem_range, clk, arst_n, rem_q < uer_pkg::REM_W'(uer_pkg::DIV_MOD))

endmodule

`default_nettype wire

[src/ultrasonic_echo_ranging_core.sv]
`default_nettype none
`include "assert_macros.svh"

// Ultrasonic echo ranging core. Each input transfer is one microsecond tick
// carrying the sampled echo level, and each tick yields exactly one output
// transfer with the trigger level, a sample strobe, the last distance in
// millimeters, a timeout flag and the phase after that tick. One tick is
// taken every clock cycle while the output side does not stall; a tick
// passes an input register and then an output register. The distance is
// kept as a running quotient and remainder that move with the pulse counter,
// so no divider holds up the phase update. Registers are written through the
// cfg port (index 0 ping period, 1 trigger width, 2 echo timeout); the user
// must write them only while no tick is in flight, which the block itself
// does not enforce. The core is ready for ticks straight out of reset.
module ultrasonic_echo_ranging_core #(
	parameter int PULSE_BITS = uer_pkg::PULSE_BITS_DEF,
	parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [7:0]                        s_axis_tdata,  // [0] echo_level
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [0] trigger_drive, [1] sample_valid, [15:2] range_mm,
	// [16] timeout_event, [19:17] ranging_phase, [23:20] zero
	output logic [23:0]                            m_axis_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CMP_W = (TIMER_BITS > uer_pkg::PERIOD_W) ? TIMER_BITS : uer_pkg::PERIOD_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
	localparam logic [PULSE_BITS-1:0] PULSE_MAX = '1;

	logic [uer_pkg::PERIOD_W-1:0]  period_q;
	logic [uer_pkg::WIDTH_W-1:0]   width_q;
	logic [uer_pkg::TIMEOUT_W-1:0] timeout_q;

	logic v_s1;
	logic echo_s1;
	logic adv;
	logic s_acc;

	logic [uer_pkg::PHASE_W-1:0] phase_q, phase_n;
	logic [TIMER_BITS-1:0]       pwc_q, pwc_n, pwc_inc;
	logic [TIMER_BITS-1:0]       stc_q, stc_n, stc_inc;
	logic [PULSE_BITS-1:0]       pulse_q, pulse_n;
	logic [uer_pkg::DIST_W-1:0]  last_dist_q, last_dist_n;
	logic [uer_pkg::DIST_W-1:0]  track_dist;
	logic                        trig_n, valid_n, tmo_n;
	logic                        ping_due, expired, width_done;
	uer_pkg::dist_ctrl_t         dctrl, dctrl_g;

	logic                        out_valid_q;
	logic                        out_trig_q, out_sample_q, out_tmo_q;
	logic [uer_pkg::DIST_W-1:0]  out_dist_q;
	logic [uer_pkg::PHASE_W-1:0] out_phase_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= uer_pkg::PING_PERIOD_RST;
			width_q   <= uer_pkg::TRIGGER_WIDTH_RST;
			timeout_q <= uer_pkg::ECHO_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uer_pkg::REG_PING_PERIOD:   period_q  <= cfg_data[uer_pkg::PERIOD_W-1:0];
				uer_pkg::REG_TRIGGER_WIDTH: width_q   <= cfg_data[uer_pkg::WIDTH_W-1:0];
				uer_pkg::REG_ECHO_TIMEOUT:  timeout_q <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	assign adv           = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			echo_s1 <= s_axis_tdata[0];
		end
	end

	// Phase update for the tick in the input register.
	assign pwc_inc = (pwc_q == TIMER_MAX) ? pwc_q : pwc_q + TIMER_BITS'(1);
	assign stc_inc = (stc_q == TIMER_MAX) ? stc_q : stc_q + TIMER_BITS'(1);

	assign ping_due   = (CMP_W'(pwc_q) >= CMP_W'(period_q)) || (pwc_q == TIMER_MAX);
	assign expired    = (CMP_W'(stc_inc) > CMP_W'(timeout_q)) || (stc_inc == TIMER_MAX);
	assign width_done = CMP_W'(stc_inc) >= CMP_W'(width_q);

	always_comb begin
		phase_n     = phase_q;
		pwc_n       = pwc_q;
		stc_n       = stc_q;
		pulse_n     = pulse_q;
		last_dist_n = last_dist_q;
		trig_n      = 1'b0;
		valid_n     = 1'b0;
		tmo_n       = 1'b0;
		dctrl       = '0;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (ping_due) begin
					if (echo_s1) begin
						// Echo stuck high at ping time.
						tmo_n   = 1'b1;
						phase_n = uer_pkg::PH_RECOVER;
					end else begin
						stc_n   = '0;
						phase_n = uer_pkg::PH_TRIG;
						trig_n  = 1'b1;
					end
				end else begin
					pwc_n = pwc_inc;
				end
			end
			uer_pkg::PH_TRIG: begin
				stc_n = stc_inc;
				if (width_done) begin
					phase_n = uer_pkg::PH_RISE;
				end else begin
					trig_n = 1'b1;
				end
			end
			uer_pkg::PH_RISE: begin
				stc_n = stc_inc;
				if (echo_s1) begin
					pulse_n     = PULSE_BITS'(1);
					dctrl.start = 1'b1;
					phase_n     = uer_pkg::PH_FALL;
				end else if (expired) begin
					tmo_n   = 1'b1;
					phase_n = uer_pkg::PH_RECOVER;
				end
			end
			uer_pkg::PH_FALL: begin
				stc_n = stc_inc;
				if (!echo_s1) begin
					last_dist_n = track_dist;
					valid_n     = 1'b1;
					pwc_n       = '0;
					phase_n     = uer_pkg::PH_IDLE;
				end else begin
					if (pulse_q != PULSE_MAX) begin
						pulse_n   = pulse_q + PULSE_BITS'(1);
						dctrl.inc = 1'b1;
					end
					if (expired) begin
						tmo_n   = 1'b1;
						phase_n = uer_pkg::PH_RECOVER;
					end
				end
			end
			default: begin
				// Recovering, and the unused codes.
				if (!echo_s1) begin
					pwc_n   = '0;
					phase_n = uer_pkg::PH_IDLE;
				end else begin
					phase_n = uer_pkg::PH_RECOVER;
				end
			end
		endcase
	end

	assign dctrl_g = adv ? dctrl : '0;

	uer_dist_track u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dctrl_g),
		.track_mm (track_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uer_pkg::PH_IDLE;
			pwc_q       <= '0;
			stc_q       <= '0;
			pulse_q     <= '0;
			last_dist_q <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			pwc_q       <= pwc_n;
			stc_q       <= stc_n;
			pulse_q     <= pulse_n;
			last_dist_q <= last_dist_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_trig_q   <= trig_n;
			out_sample_q <= valid_n;
			out_dist_q   <= last_dist_n;
			out_tmo_q    <= tmo_n;
			out_phase_q  <= phase_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_phase_q, out_tmo_q, out_dist_q, out_sample_q, out_trig_q};

	`UER_ASSERT(a_trig_phase, clk, arst_n,
		!out_valid_q || !out_trig_q || (out_phase_q == uer_pkg::PH_TRIG))
	`UER_ASSERT(a_sample_idle, clk, arst_n,
		!out_valid_q || !out_sample_q || (out_phase_q == uer_pkg::PH_IDLE))
	`UER_ASSERT(a_tmo_recover, clk, arst_n,
		!out_valid_q || !out_tmo_q || (out_phase_q == uer_pkg::PH_RECOVER))
	`UER_ASSERT_NEXT(a_sample_latched, clk, arst_n, adv && valid_n,
		last_dist_q == out_dist_q)

endmodule

`default_nettype wire
